// ----- hdl/rgb_average_prediction_filter_defines.svh -----
// ----------------------------------------------------------------------------
// RGB average prediction filter: assertion macros
// Shorthand for clocked implication checks on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef RGB_AVERAGE_PREDICTION_FILTER_DEFINES_SVH
`define RGB_AVERAGE_PREDICTION_FILTER_DEFINES_SVH

// same-cycle implication
`define RAPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rapf check failed");

// next-cycle implication
`define RAPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rapf check failed");

`endif

// ----- hdl/rapf_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB average prediction filter: package
// Shared types and fixed constants of the filter.
// ----------------------------------------------------------------------------
package rapf_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 3;
  localparam int RGB_W      = PIX_W * NUM_CH;
  localparam int WIDTH_W    = 10;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(320);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(200);

  typedef enum logic {
    MODE_FILTER   = 1'b0,
    MODE_UNFILTER = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILTER_MODE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_e;

  // position of one pixel in the frame
  typedef struct packed {
    logic has_left;
    logic has_up;
    logic last_pix;
  } pos_flags_t;

endpackage

// ----- hdl/rapf_lane.sv -----
// ----------------------------------------------------------------------------
// RGB average prediction filter: channel lane
// Forms floor((left + up) / 2) for one channel and applies it.
// ----------------------------------------------------------------------------
module rapf_lane (
  input  rapf_pkg::mode_e               mode_i,
  input  logic [rapf_pkg::PIX_W-1:0]    value_i,
  input  logic [rapf_pkg::PIX_W-1:0]    left_i,
  input  logic [rapf_pkg::PIX_W-1:0]    up_i,
  output logic [rapf_pkg::PIX_W-1:0]    result_o,
  output logic [rapf_pkg::PIX_W-1:0]    pixel_o
);
  import rapf_pkg::*;

  logic [PIX_W:0]   sum;
  logic [PIX_W-1:0] pred;

  assign sum  = {1'b0, left_i} + {1'b0, up_i};
  assign pred = sum[PIX_W:1];

  always_comb begin
    case (mode_i)
      MODE_FILTER: begin
        result_o = value_i - pred;
        pixel_o  = value_i;
      end
      MODE_UNFILTER: begin
        result_o = value_i + pred;
        pixel_o  = value_i + pred;
      end
      default: begin
        result_o = value_i - pred;
        pixel_o  = value_i;
      end
    endcase
  end

endmodule

// ----- hdl/rapf_line_store.sv -----
// ----------------------------------------------------------------------------
// RGB average prediction filter: line store
// One row of pixels, one write and one registered read port.
// ----------------------------------------------------------------------------
module rapf_line_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [rapf_pkg::RGB_W-1:0]   wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [rapf_pkg::RGB_W-1:0]   rdata_o
);
  import rapf_pkg::*;

  logic [RGB_W-1:0] mem [DEPTH];
  logic [RGB_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rapf_position.sv -----
// ----------------------------------------------------------------------------
// RGB average prediction filter: position counters
// Column and row counters against the clamped frame size.
// ----------------------------------------------------------------------------
module rapf_position #(
  parameter int MAX_WIDTH = 512,
  parameter int CW        = 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic [rapf_pkg::WIDTH_W-1:0]    image_width_i,
  input  logic [rapf_pkg::HEIGHT_W-1:0]   image_height_i,
  output logic [CW-1:0]                   column_o,
  output rapf_pkg::pos_flags_t            flags_o
);
  import rapf_pkg::*;

  localparam int PW = HEIGHT_W;

  logic [CW-1:0]    column_q, column_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [PW-1:0]    width_ext, eff_width, eff_height;
  logic             last_col, last_row;

  assign width_ext = PW'(image_width_i);

  always_comb begin
    if (width_ext == '0) begin
      eff_width = PW'(1);
    end else if (width_ext > PW'(MAX_WIDTH)) begin
      eff_width = PW'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
    if (image_height_i == '0) begin
      eff_height = PW'(1);
    end else if (image_height_i > PW'(MAX_HEIGHT)) begin
      eff_height = PW'(MAX_HEIGHT);
    end else begin
      eff_height = image_height_i;
    end
  end

  assign last_col = (PW'(column_q) + PW'(1)) >= eff_width;
  assign last_row = (PW'(row_q) + PW'(1)) >= eff_height;

  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    if (advance_i) begin
      if (last_col) begin
        column_d = '0;
        row_d    = last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        column_d = column_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

  assign column_o         = column_q;
  assign flags_o.has_left = column_q != '0;
  assign flags_o.has_up   = row_q != '0;
  assign flags_o.last_pix = last_col && last_row;

endmodule

// ----- hdl/rgb_average_prediction_filter.sv -----
// ----------------------------------------------------------------------------
// RGB average prediction filter: top level
// Average-prediction filter and unfilter for a raster stream of RGB pixels.
// ----------------------------------------------------------------------------
// Takes one pixel (or residual) per clock and returns one result per clock
// while the output is not stalled. The line store read port is registered,
// so each pixel passes through an address stage and a compute stage; three
// channel lanes then run in parallel and feed the output register. A pixel
// whose upper neighbor is still in the compute stage gets it through a bypass
// register. Configure only while idle.
module rgb_average_prediction_filter #(
  parameter int MAX_WIDTH = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rapf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rapf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [rapf_pkg::PIX_W-1:0]      red_in_i,
  input  logic [rapf_pkg::PIX_W-1:0]      green_in_i,
  input  logic [rapf_pkg::PIX_W-1:0]      blue_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rapf_pkg::PIX_W-1:0]      red_out_o,
  output logic [rapf_pkg::PIX_W-1:0]      green_out_o,
  output logic [rapf_pkg::PIX_W-1:0]      blue_out_o,
  output logic                            frame_end_o
);
  import rapf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // configuration
  mode_e               filter_mode_q;
  logic [WIDTH_W-1:0]  image_width_q;
  logic [HEIGHT_W-1:0] image_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q  <= MODE_FILTER;
      image_width_q  <= WIDTH_RESET;
      image_height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FILTER_MODE:  filter_mode_q  <= mode_e'(cfg_data_i[0]);
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_acc, s1_adv, s1_valid_q, out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  // address stage
  logic [CW-1:0] column;
  pos_flags_t    flags;

  rapf_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_position (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (in_acc),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .column_o       (column),
    .flags_o        (flags)
  );

  logic [RGB_W-1:0] s1_in_q, s1_pix, line_rdata;
  logic [CW-1:0]    s1_col_q;
  pos_flags_t       s1_flags_q;
  logic             byp_q, byp_hit;
  logic [RGB_W-1:0] byp_pix_q;

  assign byp_hit = s1_adv && (s1_col_q == column);

  rapf_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_pix),
    .re_i    (in_acc),
    .raddr_i (column),
    .rdata_o (line_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
      s1_flags_q <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        byp_q      <= byp_hit;
        s1_flags_q <= flags;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_in_q   <= {blue_in_i, green_in_i, red_in_i};
      s1_col_q  <= column;
      byp_pix_q <= s1_pix;
    end
  end

  // compute stage
  logic [RGB_W-1:0] left_q, left_nb, up_nb, up_raw, s1_res;

  assign up_raw  = byp_q ? byp_pix_q : line_rdata;
  assign left_nb = s1_flags_q.has_left ? left_q : '0;
  assign up_nb   = s1_flags_q.has_up ? up_raw : '0;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    rapf_lane u_lane (
      .mode_i   (filter_mode_q),
      .value_i  (s1_in_q[c*PIX_W +: PIX_W]),
      .left_i   (left_nb[c*PIX_W +: PIX_W]),
      .up_i     (up_nb[c*PIX_W +: PIX_W]),
      .result_o (s1_res[c*PIX_W +: PIX_W]),
      .pixel_o  (s1_pix[c*PIX_W +: PIX_W])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (s1_adv) begin
      left_q <= s1_pix;
    end
  end

  // output register
  logic [RGB_W-1:0] out_res_q;
  logic             out_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= s1_res;
      out_end_q <= s1_flags_q.last_pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_res_q[0*PIX_W +: PIX_W];
  assign green_out_o = out_res_q[1*PIX_W +: PIX_W];
  assign blue_out_o  = out_res_q[2*PIX_W +: PIX_W];
  assign frame_end_o = out_end_q;

endmodule

// ----- hdl/rapf_checker.sv -----
// ----------------------------------------------------------------------------
// RGB average prediction filter: port checker
// Watches the top-level handshakes and the number of transactions in flight.
// ----------------------------------------------------------------------------
`include "rgb_average_prediction_filter_defines.svh"

module rapf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [rapf_pkg::PIX_W-1:0]  red_out_o,
  input logic [rapf_pkg::PIX_W-1:0]  green_out_o,
  input logic [rapf_pkg::PIX_W-1:0]  blue_out_o,
  input logic                        frame_end_o
);
  import rapf_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] inflight_q, inflight_d;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      inflight_d = inflight_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  `RAPF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) && $stable(frame_end_o))
  `RAPF_ASSERT_IMPL(a_depth, 1'b1, inflight_q <= 2'd2)
  `RAPF_ASSERT_IMPL(a_empty_ready, inflight_q == 2'd0, in_ready_o)
  `RAPF_ASSERT_IMPL(a_no_phantom, out_valid_o, inflight_q != 2'd0)

endmodule

bind rgb_average_prediction_filter rapf_checker u_rapf_checker (.*);

// ----- test/tb_rgb_average_prediction_filter.sv -----
// ----------------------------------------------------------------------------
// RGB average prediction filter: testbench
// Streams RGB pixels and residuals through the filter under random flow
// control and register settings, and checks every output transaction against
// a cycle-free predictor of the average-prediction filter and unfilter.
// ----------------------------------------------------------------------------
module tb_rgb_average_prediction_filter;
  import rapf_pkg::*;

  localparam int MAX_W         = 512;
  localparam int COL_W         = $clog2(MAX_W);
  localparam int TOTAL_PIXELS  = 1900;
  localparam int CALM_TAIL     = 150;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 4;
  localparam int MAX_REPORTS   = 100;
  localparam int TIMEOUT_UNITS = 800000;

  // index past the register list; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(3);

  typedef logic [RGB_W-1:0] rgb_t;  // red 7:0, green 15:8, blue 23:16

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } filtered_px_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      red_in_i    = '0;
  logic [PIX_W-1:0]      green_in_i  = '0;
  logic [PIX_W-1:0]      blue_in_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      red_out_o;
  logic [PIX_W-1:0]      green_out_o;
  logic [PIX_W-1:0]      blue_out_o;
  logic                  frame_end_o;

  rgb_t         pixels_to_send_q[$];
  filtered_px_t filtered_q[$];

  // predictor state and register copies
  mode_e                cfg_mode   = MODE_FILTER;
  logic [WIDTH_W-1:0]   cfg_width  = WIDTH_RESET;
  logic [HEIGHT_W-1:0]  cfg_height = HEIGHT_RESET;
  logic [COL_W-1:0]     col_pos    = '0;
  logic [ROW_W-1:0]     row_pos    = '0;
  rgb_t                 left_px    = '0;
  rgb_t                 line_px[MAX_W];

  logic in_taken     = 1'b0;
  bit   calm         = 1'b0;
  bit   hold_request = 1'b0;
  int   send_gap     = 0;
  int   hold_left    = 0;
  int   err_count    = 0;
  int   pushed_total = 0;

  rgb_average_prediction_filter #(
    .MAX_WIDTH(MAX_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .frame_end_o (frame_end_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // One pixel through the average predictor; queues the transaction it yields.
  task automatic average_filter_step(input rgb_t din);
    int               w;
    int               h;
    int               c;
    rgb_t             left_nb;
    rgb_t             up_nb;
    rgb_t             pix;
    rgb_t             res;
    logic [PIX_W:0]   avg;
    logic [PIX_W-1:0] v;
    logic             last_col;
    logic             last_row;
    filtered_px_t     r;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height));
    left_nb = (col_pos != 0) ? left_px : '0;
    up_nb = (row_pos != 0) ? line_px[col_pos] : '0;
    for (c = 0; c < NUM_CH; c++) begin
      v = din[c*PIX_W +: PIX_W];
      avg = ({1'b0, left_nb[c*PIX_W +: PIX_W]} + {1'b0, up_nb[c*PIX_W +: PIX_W]}) >> 1;
      if (cfg_mode == MODE_FILTER) begin
        res[c*PIX_W +: PIX_W] = v - avg[PIX_W-1:0];
        pix[c*PIX_W +: PIX_W] = v;
      end else begin
        res[c*PIX_W +: PIX_W] = v + avg[PIX_W-1:0];
        pix[c*PIX_W +: PIX_W] = res[c*PIX_W +: PIX_W];
      end
    end
    left_px = pix;
    line_px[col_pos] = pix;
    last_col = (int'(col_pos) + 1 >= w);
    last_row = (int'(row_pos) + 1 >= h);
    r.red = res[PIX_W-1:0];
    r.green = res[2*PIX_W-1:PIX_W];
    r.blue = res[3*PIX_W-1:2*PIX_W];
    r.frame_end = last_col && last_row;
    filtered_q.push_back(r);
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + ROW_W'(1);
    end else begin
      col_pos = col_pos + COL_W'(1);
    end
  endtask

  // Accept on the rising edge: feed the predictor and check the output side.
  always @(posedge clk_i) begin
    filtered_px_t e;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        average_filter_step({blue_in_i, green_in_i, red_in_i});
      end
      if (out_valid_o && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          report_mismatch("unexpected transaction, red", '0, 32'(red_out_o));
        end else begin
          e = filtered_q.pop_front();
          if (red_out_o !== e.red) begin
            report_mismatch("red_out", 32'(e.red), 32'(red_out_o));
          end
          if (green_out_o !== e.green) begin
            report_mismatch("green_out", 32'(e.green), 32'(green_out_o));
          end
          if (blue_out_o !== e.blue) begin
            report_mismatch("blue_out", 32'(e.blue), 32'(blue_out_o));
          end
          if (frame_end_o !== e.frame_end) begin
            report_mismatch("frame_end", 32'(e.frame_end), 32'(frame_end_o));
          end
        end
      end
    end
  end

  // Pixel driver: hold until accepted, then idle a burst or present the next.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold
      end else if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap = send_gap - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_valid_i <= 1'b0;
        send_gap = $urandom_range(0, 7);
      end else if (pixels_to_send_q.size() != 0) begin
        {blue_in_i, green_in_i, red_in_i} <= pixels_to_send_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output consumer: random stall bursts plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left = hold_left - 1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        hold_left = LONG_HOLD - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        hold_left = $urandom_range(0, 7);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic wait_for_idle();
    @(negedge clk_i);
    while (pixels_to_send_q.size() != 0 || in_valid_i || filtered_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_FILTER_MODE:  cfg_mode = mode_e'(data[0]);
      CFG_IMAGE_WIDTH:  cfg_width = data[WIDTH_W-1:0];
      CFG_IMAGE_HEIGHT: cfg_height = data[HEIGHT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(input mode_e m, input logic [CFG_DATA_W-1:0] w,
                           input logic [CFG_DATA_W-1:0] h);
    wait_for_idle();
    write_reg(CFG_FILTER_MODE, CFG_DATA_W'(m));
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic push_px(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                         input logic [PIX_W-1:0] b);
    pixels_to_send_q.push_back({b, g, r});
    pushed_total++;
  endtask

  task automatic push_random(input int n);
    repeat (n) push_px(PIX_W'($urandom()), PIX_W'($urandom()), PIX_W'($urandom()));
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    int                    n;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // two-row frame with extreme bytes
    configure(MODE_FILTER, 3, 2);
    push_px(8'h00, 8'h00, 8'h00);
    push_px(8'hFF, 8'hFF, 8'hFF);
    push_px(8'h00, 8'hFF, 8'h80);
    push_px(8'hFF, 8'h00, 8'h7F);
    push_px(8'h01, 8'hFE, 8'h55);
    push_px(8'hAA, 8'h55, 8'hFF);
    // single-pixel frames, then zero sizes that count as one
    configure(MODE_UNFILTER, 1, 1);
    push_px(8'hFF, 8'hFF, 8'hFF);
    push_px(8'h00, 8'h80, 8'h01);
    configure(MODE_FILTER, 0, 0);
    push_px(8'h7F, 8'h80, 8'hFF);
    push_px(8'hFF, 8'h01, 8'h00);
    // spare index must not disturb anything
    wait_for_idle();
    write_reg(CFG_IDX_SPARE, '1);
    // oversize registers clamp
    configure(MODE_UNFILTER, 1023, 8191);
    push_px(8'hFF, 8'h00, 8'hFF);
    push_px(8'h80, 8'hFF, 8'h01);
    push_px(8'hFE, 8'h7F, 8'h00);
    // shrink width past the current column: the row ends at once
    configure(MODE_UNFILTER, 2, 8191);
    push_px(8'h33, 8'hCC, 8'hFF);
    // flip mode mid-frame, then shrink height past the current row
    configure(MODE_FILTER, 2, 8191);
    push_px(8'hFF, 8'hFF, 8'h00);
    push_px(8'h01, 8'h02, 8'h03);
    configure(MODE_FILTER, 2, 1);
    push_px(8'hC0, 8'h3F, 8'hFF);
    push_px(8'h00, 8'hFF, 8'h10);

    // one full-width row fills every line entry; stall the output meanwhile
    configure(mode_e'($urandom_range(0, 1)), CFG_DATA_W'(MAX_W), 1);
    hold_request = 1'b1;
    push_random(MAX_W);

    while (pushed_total < TOTAL_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = CFG_DATA_W'(MAX_W);
        2:       w = CFG_DATA_W'($urandom_range(MAX_W + 1, 1023));
        3:       w = CFG_DATA_W'($urandom());
        default: w = CFG_DATA_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 9))
        0:       h = 0;
        1:       h = CFG_DATA_W'(MAX_HEIGHT);
        2:       h = 8191;
        3:       h = CFG_DATA_W'($urandom());
        default: h = CFG_DATA_W'($urandom_range(1, 6));
      endcase
      n = $urandom_range(3, 40);
      if (n > TOTAL_PIXELS - pushed_total) n = TOTAL_PIXELS - pushed_total;
      configure(mode_e'($urandom_range(0, 1)), w, h);
      if (pushed_total >= TOTAL_PIXELS - CALM_TAIL) calm = 1'b1;
      push_random(n);
    end

    wait_for_idle();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
